// ----- sv/cbor_pkg.sv -----
`default_nettype none

package cbor_pkg;

	localparam int unsigned NOW_W    = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned STEP_W   = 8;

	// output buffer: room for the item in flight plus two waiting results
	localparam int unsigned OBUF_DEPTH = 3;
	localparam int unsigned OBUF_AW    = 2;
	localparam int unsigned OBUF_CW    = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_SCHEDULE_TICKS   = 3'd0,
		REG_FAST_PERIOD      = 3'd1,
		REG_SLOW_PERIOD      = 3'd2,
		REG_FAST_RETRY_LIMIT = 3'd3,
		REG_SENT_THRESHOLD   = 3'd4,
		REG_SENT_STEP        = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0]  RST_SCHEDULE_TICKS   = 16'd10;
	localparam logic [CFG_W-1:0]  RST_FAST_PERIOD      = 16'd100;
	localparam logic [CFG_W-1:0]  RST_SLOW_PERIOD      = 16'd1000;
	localparam logic [CFG_W-1:0]  RST_FAST_RETRY_LIMIT = 16'd10;
	localparam logic [CFG_W-1:0]  RST_SENT_THRESHOLD   = 16'd2;
	localparam logic [STEP_W-1:0] RST_SENT_STEP        = 8'd1;

	typedef enum logic {
		ACT_TICK    = 1'b0,
		ACT_TX_DONE = 1'b1
	} action_t;

	typedef struct packed {
		logic             action;
		logic [1:0]       fault_state;
		logic [NOW_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic recover_mode;
		logic bus_off_flag;
		logic clear_send_buffers;
		logic auto_recover_enable;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0]  schedule_ticks;
		logic [CFG_W-1:0]  fast_period;
		logic [CFG_W-1:0]  slow_period;
		logic [CFG_W-1:0]  fast_retry_limit;
		logic [CFG_W-1:0]  sent_threshold;
		logic [STEP_W-1:0] sent_step;
	} cfg_t;

endpackage

`default_nettype wire

// ----- sv/cbor_stream_if.sv -----
`default_nettype none

interface cbor_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/cbor_cfg_regs.sv -----
`default_nettype none

module cbor_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cbor_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [cbor_pkg::CFG_W-1:0]  cfg_data,
	output cbor_pkg::cfg_t                   cfg
);

	cbor_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.schedule_ticks   <= cbor_pkg::RST_SCHEDULE_TICKS;
			cfg_q.fast_period      <= cbor_pkg::RST_FAST_PERIOD;
			cfg_q.slow_period      <= cbor_pkg::RST_SLOW_PERIOD;
			cfg_q.fast_retry_limit <= cbor_pkg::RST_FAST_RETRY_LIMIT;
			cfg_q.sent_threshold   <= cbor_pkg::RST_SENT_THRESHOLD;
			cfg_q.sent_step        <= cbor_pkg::RST_SENT_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				cbor_pkg::REG_SCHEDULE_TICKS:   cfg_q.schedule_ticks   <= cfg_data;
				cbor_pkg::REG_FAST_PERIOD:      cfg_q.fast_period      <= cfg_data;
				cbor_pkg::REG_SLOW_PERIOD:      cfg_q.slow_period      <= cfg_data;
				cbor_pkg::REG_FAST_RETRY_LIMIT: cfg_q.fast_retry_limit <= cfg_data;
				cbor_pkg::REG_SENT_THRESHOLD:   cfg_q.sent_threshold   <= cfg_data;
				cbor_pkg::REG_SENT_STEP:
					cfg_q.sent_step <= cfg_data[cbor_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- sv/cbor_core.sv -----
`default_nettype none

module cbor_core #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cbor_pkg::cfg_t cfg,
	input  wire logic           accept,
	input  wire cbor_pkg::item_t item,
	output logic                busy,
	output logic                push,
	output cbor_pkg::result_t   push_data
);

	localparam int unsigned CW = (TIME_WIDTH > cbor_pkg::CFG_W) ? TIME_WIDTH : cbor_pkg::CFG_W;
	localparam int unsigned SW = cbor_pkg::COUNT_W;

	logic            valid_s1;
	cbor_pkg::item_t item_s1;

	logic [SW-1:0]         sched_q, sched_n;
	logic                  inrec_q, inrec_n;
	logic                  mark_q, mark_n;
	logic                  slow_q, slow_n;
	logic                  auto_q, auto_n;
	logic [TIME_WIDTH-1:0] last_q, last_n;
	logic [SW-1:0]         attempt_q, attempt_n;
	logic [SW-1:0]         sent_q, sent_n;
	logic                  clear;

	logic                  run;
	logic                  off;
	logic                  due;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [SW-1:0]         period;
	logic [SW:0]           sent_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign now_t    = TIME_WIDTH'(item_s1.now_ms);
	assign elapsed  = now_t - last_q;
	assign period   = slow_q ? cfg.slow_period : cfg.fast_period;
	assign due      = CW'(period) <= CW'(elapsed);
	assign run      = sched_q >= cfg.schedule_ticks;
	assign off      = item_s1.fault_state[1];
	assign sent_sum = (SW+1)'(sent_q) + (SW+1)'(cfg.sent_step);

	always_comb begin
		sched_n   = sched_q;
		inrec_n   = inrec_q;
		mark_n    = mark_q;
		slow_n    = slow_q;
		auto_n    = auto_q;
		last_n    = last_q;
		attempt_n = attempt_q;
		sent_n    = sent_q;
		clear     = 1'b0;
		if (valid_s1) begin
			if (item_s1.action == cbor_pkg::ACT_TX_DONE) begin
				sent_n = sent_sum[SW] ? '1 : sent_sum[SW-1:0];
			end else begin
				if (run) begin
					if (!inrec_q) begin
						if (off) begin
							inrec_n   = 1'b1;
							mark_n    = 1'b1;
							clear     = 1'b1;
							sent_n    = '0;
							auto_n    = 1'b1;
							slow_n    = 1'b0;
							last_n    = now_t;
							attempt_n = '0;
						end
					end else if (due) begin
						last_n = now_t;
						if (attempt_q < cfg.fast_retry_limit) begin
							attempt_n = attempt_q + 1'b1;
						end else begin
							slow_n = 1'b1;
						end
						if (!off && sent_q >= cfg.sent_threshold) begin
							attempt_n = '0;
							slow_n    = 1'b0;
							auto_n    = 1'b0;
							mark_n    = 1'b0;
							inrec_n   = 1'b0;
						end else begin
							clear = 1'b1;
						end
					end
					// divider restarts after a diagnosis run, then counts this tick
					sched_n = SW'(1);
				end else begin
					sched_n = sched_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_q   <= '0;
			inrec_q   <= 1'b0;
			mark_q    <= 1'b0;
			slow_q    <= 1'b0;
			auto_q    <= 1'b0;
			last_q    <= '0;
			attempt_q <= '0;
			sent_q    <= '0;
		end else begin
			sched_q   <= sched_n;
			inrec_q   <= inrec_n;
			mark_q    <= mark_n;
			slow_q    <= slow_n;
			auto_q    <= auto_n;
			last_q    <= last_n;
			attempt_q <= attempt_n;
			sent_q    <= sent_n;
		end
	end

	assign busy                         = valid_s1;
	assign push                         = valid_s1;
	assign push_data.recover_mode        = inrec_n;
	assign push_data.bus_off_flag        = mark_n;
	assign push_data.clear_send_buffers  = clear;
	assign push_data.auto_recover_enable = auto_n;

endmodule

`default_nettype wire

// ----- sv/cbor_out_buf.sv -----
`default_nettype none

module cbor_out_buf (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire cbor_pkg::result_t             push_data,
	output logic [cbor_pkg::OBUF_CW-1:0]       count,
	cbor_stream_if.source                      result
);

	localparam int unsigned DEPTH = cbor_pkg::OBUF_DEPTH;
	localparam int unsigned AW    = cbor_pkg::OBUF_AW;
	localparam int unsigned CW    = cbor_pkg::OBUF_CW;

	cbor_pkg::result_t entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign pop = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign count          = count_q;
	assign result.valid   = count_q != '0;
	assign result.payload = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- sv/can_bus_off_recovery_monitor_top.sv -----
// CAN bus-off recovery supervisor.
// item channel: one transaction per supervisor tick (action 0) or per frame sent
// OK (action 1), with the controller fault state and the free-running ms count.
// result channel: one transaction per item, showing the state after that item:
// recovery mode, bus-off flag, transmit-buffer clear pulse, auto-recover enable.
// cfg port: cfg_we/cfg_index/cfg_data write the six timing and threshold
// registers; write them only while no item is in flight.
// Items pass the input register and the state update into the result buffer.
// Throughput: one item per cycle while item.ready is high, with the state update
// loop (divider, retry timer, attempt and sent counters) behind the input register.
// A three-entry result buffer lets items keep flowing while the receiver holds
// off; item.ready drops only once the buffer plus the item in flight are full.
// Reset (arst_n low) returns to normal mode with all counters and flags clear and
// the registers at their defaults. No item is to be accepted during reset: the
// sender must hold items off then, as the block itself does not enforce it.
`default_nettype none

module can_bus_off_recovery_monitor_top #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cbor_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [cbor_pkg::CFG_W-1:0]  cfg_data,
	cbor_stream_if.sink                      item,
	cbor_stream_if.source                    result
);

	cbor_pkg::cfg_t                cfg;
	cbor_pkg::result_t             push_data;
	logic                          push;
	logic                          busy;
	logic                          accept;
	logic [cbor_pkg::OBUF_CW-1:0]  count;
	logic [cbor_pkg::OBUF_CW:0]    occupied;

	assign occupied   = (cbor_pkg::OBUF_CW+1)'(count) + (cbor_pkg::OBUF_CW+1)'(busy);
	assign item.ready = occupied < (cbor_pkg::OBUF_CW+1)'(cbor_pkg::OBUF_DEPTH);
	assign accept     = item.valid && item.ready;

	cbor_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cbor_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.item      (item.payload),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	cbor_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.count     (count),
		.result    (result)
	);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import cbor_pkg::*;

	localparam int unsigned STALL_LIMIT = 500;
	localparam int unsigned LONG_HOLD   = 60;

	typedef struct {
		item_t       pkt;
		int unsigned gap;
	} pend_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	cbor_stream_if #(.payload_t(item_t)) item_ch ();
	cbor_stream_if #(.payload_t(result_t)) result_ch ();

	can_bus_off_recovery_monitor_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// supervisor shadow: registers
	logic [CFG_W-1:0]  c_sched  = RST_SCHEDULE_TICKS;
	logic [CFG_W-1:0]  c_fast   = RST_FAST_PERIOD;
	logic [CFG_W-1:0]  c_slow   = RST_SLOW_PERIOD;
	logic [CFG_W-1:0]  c_limit  = RST_FAST_RETRY_LIMIT;
	logic [CFG_W-1:0]  c_thresh = RST_SENT_THRESHOLD;
	logic [STEP_W-1:0] c_step   = RST_SENT_STEP;

	// supervisor shadow: state
	logic [COUNT_W-1:0] m_div_cnt = '0;
	logic               m_in_rec  = 1'b0;
	logic               m_mark    = 1'b0;
	logic               m_slow    = 1'b0;
	logic               m_auto    = 1'b0;
	logic [NOW_W-1:0]   m_last    = '0;
	logic [COUNT_W-1:0] m_attempts = '0;
	logic [COUNT_W-1:0] m_sent    = '0;

	pend_item_t  pend_q[$];
	result_t     status_q[$];
	int unsigned err_count = 0;
	int unsigned res_count = 0;
	int unsigned tx_gap_max = 0;
	int unsigned rx_gap_max = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned stall_cnt = 0;
	logic        in_taken = 1'b0;
	logic        res_taken = 1'b0;
	logic [NOW_W-1:0] ms_clock = '0;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// one item through the supervisor; returns the status after it
	task automatic supervise(input item_t it, output result_t r);
		logic             off;
		logic             clr;
		logic [NOW_W-1:0] elapsed;
		logic [CFG_W-1:0] period;
		logic [16:0]      sum;
		clr = 1'b0;
		if (action_t'(it.action) == ACT_TX_DONE) begin
			sum = {1'b0, m_sent} + {9'd0, c_step};
			m_sent = sum[16] ? 16'hFFFF : sum[15:0];
		end else begin
			off = it.fault_state[1];
			if (m_div_cnt >= c_sched) begin
				if (!m_in_rec) begin
					if (off) begin
						m_in_rec = 1'b1;
						m_mark = 1'b1;
						clr = 1'b1;
						m_sent = '0;
						m_auto = 1'b1;
						m_slow = 1'b0;
						m_last = it.now_ms;
						m_attempts = '0;
					end
				end else begin
					elapsed = it.now_ms - m_last;
					period = m_slow ? c_slow : c_fast;
					if (elapsed >= period) begin
						m_last = it.now_ms;
						if (m_attempts < c_limit)
							m_attempts = m_attempts + 1'b1;
						else
							m_slow = 1'b1;
						if (!off && m_sent >= c_thresh) begin
							m_attempts = '0;
							m_slow = 1'b0;
							m_auto = 1'b0;
							m_mark = 1'b0;
							m_in_rec = 1'b0;
						end else begin
							clr = 1'b1;
						end
					end
				end
				m_div_cnt = '0;
			end
			m_div_cnt = m_div_cnt + 1'b1;
		end
		r.recover_mode = m_in_rec;
		r.bus_off_flag = m_mark;
		r.clear_send_buffers = clr;
		r.auto_recover_enable = m_auto;
	endtask

	// scoreboard: results first, then the new item, then register writes
	always @(posedge clk) begin : mon
		result_t got;
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				if (status_q.size() == 0) begin
					report_error($sformatf("result %b with nothing expected", got));
				end else begin
					want = status_q.pop_front();
					if (got.recover_mode !== want.recover_mode)
						report_error($sformatf("recover_mode got %b want %b",
							got.recover_mode, want.recover_mode));
					if (got.bus_off_flag !== want.bus_off_flag)
						report_error($sformatf("bus_off_flag got %b want %b",
							got.bus_off_flag, want.bus_off_flag));
					if (got.clear_send_buffers !== want.clear_send_buffers)
						report_error($sformatf("clear_send_buffers got %b want %b",
							got.clear_send_buffers, want.clear_send_buffers));
					if (got.auto_recover_enable !== want.auto_recover_enable)
						report_error($sformatf("auto_recover_enable got %b want %b",
							got.auto_recover_enable, want.auto_recover_enable));
				end
				res_count <= res_count + 1;
			end
			if (item_ch.valid && item_ch.ready) begin
				supervise(item_ch.payload, pred);
				status_q.push_back(pred);
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SCHEDULE_TICKS:   c_sched = cfg_data;
					REG_FAST_PERIOD:      c_fast = cfg_data;
					REG_SLOW_PERIOD:      c_slow = cfg_data;
					REG_FAST_RETRY_LIMIT: c_limit = cfg_data;
					REG_SENT_THRESHOLD:   c_thresh = cfg_data;
					REG_SENT_STEP:        c_step = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			in_taken <= item_ch.valid && item_ch.ready;
			res_taken <= result_ch.valid && result_ch.ready;
		end
	end

	// sender: each item waits its own gap after the previous transaction
	always @(negedge clk) begin : drv
		logic  nv;
		item_t np;
		if (arst_n) begin
			nv = item_ch.valid;
			np = item_ch.payload;
			if (in_taken)
				nv = 1'b0;
			if (!nv && pend_q.size() > 0) begin
				if (tx_wait >= pend_q[0].gap) begin
					np = pend_q[0].pkt;
					void'(pend_q.pop_front());
					nv = 1'b1;
					tx_wait = 0;
				end else begin
					tx_wait++;
				end
			end
			item_ch.valid <= nv;
			item_ch.payload <= np;
		end
	end

	// receiver: per-result hold-off, with a long hold twice in the run
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken)
				rx_wait = (res_count == 100 || res_count == 350) ? LONG_HOLD
					: $urandom_range(0, rx_gap_max);
			if (rx_wait > 0) begin
				rx_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
					cfg_we)
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic add_item(input action_t a, input logic [1:0] fs, input logic [NOW_W-1:0] now);
		pend_item_t p;
		p.pkt.action = a;
		p.pkt.fault_state = fs;
		p.pkt.now_ms = now;
		p.gap = $urandom_range(0, tx_gap_max);
		pend_q.push_back(p);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pend_q.size() != 0 || item_ch.valid || status_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_cfg(input cfg_t c);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCHEDULE_TICKS;
		cfg_data <= c.schedule_ticks;
		@(negedge clk);
		cfg_index <= REG_FAST_PERIOD;
		cfg_data <= c.fast_period;
		@(negedge clk);
		cfg_index <= REG_SLOW_PERIOD;
		cfg_data <= c.slow_period;
		@(negedge clk);
		cfg_index <= REG_FAST_RETRY_LIMIT;
		cfg_data <= c.fast_retry_limit;
		@(negedge clk);
		cfg_index <= REG_SENT_THRESHOLD;
		cfg_data <= c.sent_threshold;
		@(negedge clk);
		cfg_index <= REG_SENT_STEP;
		cfg_data <= {{(CFG_W-STEP_W){1'b0}}, c.sent_step};
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly coherent traffic: rising ms count, bus state held in stretches
	task automatic run_phase(input cfg_t c, input int n, input int unsigned ms_max,
			input int unsigned tx_pct, input int unsigned tx_gm, input int unsigned rx_gm);
		logic [1:0] bus_fs;
		bus_fs = 2'd0;
		load_cfg(c);
		tx_gap_max = tx_gm;
		rx_gap_max = rx_gm;
		ms_clock = 16'($urandom_range(0, 16'hFFFF));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 12)
				bus_fs = $urandom_range(0, 1) ? 2'd2 : 2'($urandom_range(0, 3));
			ms_clock = ms_clock + 16'($urandom_range(0, ms_max));
			if ($urandom_range(0, 99) < tx_pct)
				add_item(ACT_TX_DONE, 2'($urandom_range(0, 3)), 16'($urandom()));
			else if ($urandom_range(0, 19) == 0)
				add_item(ACT_TICK, 2'($urandom_range(0, 3)), 16'($urandom()));
			else
				add_item(ACT_TICK, bus_fs, ms_clock);
		end
		wait_idle();
	endtask

	initial begin
		cfg_t c;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: every tick is a diagnosis, zero fast period
		c = '{schedule_ticks: 16'd0, fast_period: 16'd0, slow_period: 16'd3,
			fast_retry_limit: 16'd2, sent_threshold: 16'd2, sent_step: 8'd1};
		load_cfg(c);
		tx_gap_max = 2;
		rx_gap_max = 2;
		add_item(ACT_TICK, 2'd0, 16'h0000);
		add_item(ACT_TICK, 2'd1, 16'hFFFF);
		add_item(ACT_TICK, 2'd2, 16'h0010);
		add_item(ACT_TICK, 2'd2, 16'h0010);
		add_item(ACT_TX_DONE, 2'd3, 16'hFFFF);
		add_item(ACT_TICK, 2'd3, 16'h8000);  // fault state three counts as bus off
		add_item(ACT_TICK, 2'd0, 16'h8000);  // retry limit hit, goes slow
		add_item(ACT_TICK, 2'd0, 16'h8001);
		add_item(ACT_TX_DONE, 2'd0, 16'h0000);
		add_item(ACT_TICK, 2'd0, 16'h8002);
		add_item(ACT_TICK, 2'd1, 16'h8003);  // slow period elapsed, leaves recovery
		add_item(ACT_TICK, 2'd2, 16'hFFFE);
		add_item(ACT_TX_DONE, 2'd1, 16'h1234);
		add_item(ACT_TX_DONE, 2'd2, 16'hABCD);
		add_item(ACT_TX_DONE, 2'd0, 16'h5555);
		add_item(ACT_TICK, 2'd0, 16'h0001);
		add_item(ACT_TICK, 2'd3, 16'h5555);
		add_item(ACT_TICK, 2'd2, 16'hAAAA);
		add_item(ACT_TICK, 2'd1, 16'hFFFF);
		wait_idle();

		c = '{schedule_ticks: 16'd0, fast_period: 16'd1, slow_period: 16'd1,
			fast_retry_limit: 16'd0, sent_threshold: 16'd0, sent_step: 8'd255};
		run_phase(c, 25, 3, 30, 8, 8);
		c = '{schedule_ticks: 16'd1, fast_period: 16'd20, slow_period: 16'd60,
			fast_retry_limit: 16'd3, sent_threshold: 16'd3, sent_step: 8'd1};
		run_phase(c, 40, 15, 30, 0, 0);
		c = '{schedule_ticks: 16'd2, fast_period: 16'd50, slow_period: 16'd200,
			fast_retry_limit: 16'd2, sent_threshold: 16'd5, sent_step: 8'd2};
		run_phase(c, 40, 40, 35, 8, 8);
		c = '{schedule_ticks: RST_SCHEDULE_TICKS, fast_period: RST_FAST_PERIOD,
			slow_period: RST_SLOW_PERIOD, fast_retry_limit: RST_FAST_RETRY_LIMIT,
			sent_threshold: RST_SENT_THRESHOLD, sent_step: RST_SENT_STEP};
		run_phase(c, 25, 200, 25, 4, 6);
		// divider lowered below its count
		c = '{schedule_ticks: 16'($urandom_range(0, 3)), fast_period: 16'($urandom_range(1, 30)),
			slow_period: 16'($urandom_range(1, 100)),
			fast_retry_limit: 16'($urandom_range(0, 5)),
			sent_threshold: 16'($urandom_range(0, 6)), sent_step: 8'($urandom_range(0, 3))};
		run_phase(c, 40, 30, 30, 8, 3);

		// all but the divider at the top: sent counter saturates, then a full-range wait
		c = '{schedule_ticks: 16'd0, fast_period: 16'hFFFF, slow_period: 16'hFFFF,
			fast_retry_limit: 16'hFFFF, sent_threshold: 16'hFFFF, sent_step: 8'd255};
		load_cfg(c);
		tx_gap_max = 0;
		rx_gap_max = 8;
		if (!m_in_rec) begin
			add_item(ACT_TICK, 2'd2, 16'($urandom()));
			wait_idle();
		end
		for (int i = 0; i < 258; i++)
			add_item(ACT_TX_DONE, 2'($urandom_range(0, 3)), 16'($urandom()));
		wait_idle();
		add_item(ACT_TICK, 2'd0, m_last - 1'b1);
		add_item(ACT_TICK, 2'd2, 16'($urandom()));
		wait_idle();
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/cbor_pkg.sv
sv/cbor_stream_if.sv
sv/cbor_cfg_regs.sv
sv/cbor_core.sv
sv/cbor_out_buf.sv
sv/can_bus_off_recovery_monitor_top.sv
tb/tb.sv
